// ----- src/drq_pkg.sv -----
// shared types, constants and codes for the deadline reminder queue
`default_nettype none

package drq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W        = 10;
  localparam int STAMP_W     = 40;
  localparam int KIND_W      = 2;
  localparam int CODE_W      = 2;
  localparam int SLOT_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [ID_W-1:0] ID_TOP = ID_W'(999);

  // request kinds, code 3 carries no meaning
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DELETED  = 2'd1,
    ST_FAIL     = 2'd2,
    ST_EXPIRED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ACT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] due;
    logic [STAMP_W-1:0] start;
    logic [CODE_W-1:0]  etype;
    logic [CODE_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic              capture;
    logic              scan_start;
    logic              scan_rd;
    logic [SLOT_W-1:0] scan_addr;
    logic              ins_commit;
    logic              del_commit;
    logic              tick_take;
    logic              tick_flush;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              best_found;
    logic              pend_valid;
    logic              out_free;
    logic              res_full;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/drq_ctrl.sv -----
// controller state machine: slot scans and commit sequencing
`default_nettype none

module drq_ctrl import drq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_stall,
  input  wire sts_t              sts,
  output cmd_t                   cmd
);

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic              accept;
  logic              known_kind;
  logic              scan_end;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign known_kind = (in_kind == KIND_INSERT) || (in_kind == KIND_DELETE) ||
                      (in_kind == KIND_TICK);
  assign scan_end   = (scan_cnt_r == SLOT_W'(DEPTH - 1));
  assign in_stall   = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && known_kind) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        unique case (sts.kind)
          KIND_INSERT, KIND_DELETE: begin
            if (sts.out_free) state_nxt = S_IDLE;
          end
          KIND_TICK: begin
            if (sts.best_found) begin
              if (!sts.pend_valid || sts.out_free) begin
                state_nxt = sts.res_full ? S_FLUSH : S_SCAN;
              end
            end else begin
              state_nxt = sts.pend_valid ? S_FLUSH : S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FLUSH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd           = '0;
    cmd.scan_addr = scan_cnt_r;
    scan_cnt_nxt  = scan_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture    = 1'b1;
          cmd.scan_start = 1'b1;
          scan_cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (!scan_end) scan_cnt_nxt = scan_cnt_r + SLOT_W'(1);
      end
      S_DRAIN: begin
      end
      S_ACT: begin
        unique case (sts.kind)
          KIND_INSERT: cmd.ins_commit = sts.out_free;
          KIND_DELETE: cmd.del_commit = sts.out_free;
          KIND_TICK: begin
            if (sts.best_found && (!sts.pend_valid || sts.out_free)) begin
              cmd.tick_take = 1'b1;
              if (!sts.res_full) begin
                cmd.scan_start = 1'b1;
                scan_cnt_nxt   = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_FLUSH: begin
        cmd.tick_flush = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/drq_datapath.sv -----
// datapath: entry memory, slot valid and age cells, best-candidate search, result register
`default_nettype none

module drq_datapath import drq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [STAMP_W-1:0] in_remind_stamp,
  input  wire logic [STAMP_W-1:0] in_start_stamp,
  input  wire logic [CODE_W-1:0]  in_entry_type,
  input  wire logic [CODE_W-1:0]  in_priority_req,
  input  wire logic [ID_W-1:0]    in_target_id,
  input  wire logic [STAMP_W-1:0] in_now_stamp,
  input  wire logic               cfg_wr_en,
  input  wire logic [ID_W-1:0]    cfg_wr_data,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [ID_W-1:0]         out_entry_id,
  output logic [STAMP_W-1:0]      out_due_stamp,
  output logic [STAMP_W-1:0]      out_begin_stamp,
  output logic [CODE_W-1:0]       out_type,
  output logic [CODE_W-1:0]       out_priority,
  output logic                    out_last
);

  // captured request
  logic [KIND_W-1:0]  req_kind_r;
  logic [STAMP_W-1:0] req_remind_r;
  logic [STAMP_W-1:0] req_start_r;
  logic [CODE_W-1:0]  req_type_r;
  logic [CODE_W-1:0]  req_prio_r;
  logic [ID_W-1:0]    req_tid_r;
  logic [STAMP_W-1:0] req_now_r;

  // slot storage
  entry_t             mem_r [DEPTH];
  entry_t             mem_q_r;
  logic [DEPTH-1:0]   valid_r, valid_nxt;
  logic [SLOT_W-1:0]  age_r [DEPTH];
  logic [SLOT_W-1:0]  age_nxt [DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_W-1:0]    id_counter_r;
  logic [ID_W-1:0]    new_id;

  // search pipeline
  logic               cand_vld_r;
  logic [SLOT_W-1:0]  cand_idx_r;
  logic               cand_valid;
  logic [SLOT_W-1:0]  cand_age;
  logic               take;
  logic               best_found_r;
  logic [SLOT_W-1:0]  best_idx_r;
  logic [SLOT_W-1:0]  best_age_r;
  entry_t             best_entry_r;

  // expired entry held until the next one is known
  logic               pend_valid_r;
  entry_t             pend_r;
  logic [RES_W-1:0]   res_cnt_r;

  logic               ins_do;
  logic               drop_en;
  entry_t             ins_entry;

  logic               out_valid_r;
  logic               out_load;
  logic               out_free;
  status_t            out_status_r, st_nxt;
  logic [ID_W-1:0]    out_id_r, id_nxt;
  logic [STAMP_W-1:0] out_due_r, due_nxt;
  logic [STAMP_W-1:0] out_begin_r, begin_nxt;
  logic [CODE_W-1:0]  out_type_r, type_nxt;
  logic [CODE_W-1:0]  out_prio_r, prio_nxt;
  logic               out_last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind_r   <= in_kind;
      req_remind_r <= in_remind_stamp;
      req_start_r  <= in_start_stamp;
      req_type_r   <= in_entry_type;
      req_prio_r   <= in_priority_req;
      req_tid_r    <= in_target_id;
      req_now_r    <= in_now_stamp;
    end
  end

  assign new_id  = (id_counter_r >= ID_TOP) ? '0 : id_counter_r + ID_W'(1);
  assign ins_do  = cmd.ins_commit && best_found_r;
  assign drop_en = (cmd.del_commit && best_found_r) || cmd.tick_take;

  always_comb begin
    ins_entry.id    = new_id;
    ins_entry.due   = req_remind_r;
    ins_entry.start = req_start_r;
    ins_entry.etype = req_type_r;
    ins_entry.prio  = req_prio_r;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ins_do) mem_r[best_idx_r] <= ins_entry;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) mem_q_r <= mem_r[cmd.scan_addr];
    cand_idx_r <= cmd.scan_addr;
  end

  // candidate compare against running best
  assign cand_valid = valid_r[cand_idx_r];
  assign cand_age   = age_r[cand_idx_r];

  always_comb begin
    take = 1'b0;
    unique case (req_kind_r)
      KIND_INSERT: take = !cand_valid && !best_found_r;
      KIND_DELETE: take = cand_valid && (mem_q_r.id == req_tid_r) &&
                          (!best_found_r || (cand_age < best_age_r));
      KIND_TICK:   take = cand_valid && (mem_q_r.due < req_now_r) &&
                          (!best_found_r || (mem_q_r.due < best_entry_r.due) ||
                           ((mem_q_r.due == best_entry_r.due) &&
                            (cand_age < best_age_r)));
      default:     take = 1'b0;
    endcase
    take = take && cand_vld_r;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r   <= cand_idx_r;
      best_age_r   <= cand_age;
      best_entry_r <= mem_q_r;
    end
  end

  // slot valid bits and insertion ranks
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) age_nxt[i] = age_r[i];
    if (ins_do) begin
      valid_nxt[best_idx_r] = 1'b1;
      age_nxt[best_idx_r]   = count_r[SLOT_W-1:0];
      count_nxt             = count_r + CNT_W'(1);
    end
    if (drop_en) begin
      valid_nxt[best_idx_r] = 1'b0;
      count_nxt             = count_r - CNT_W'(1);
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_r[i] && (age_r[i] > best_age_r)) age_nxt[i] = age_r[i] - SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) age_r[i] <= age_nxt[i];
    if (cmd.tick_take) pend_r <= best_entry_r;
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.ins_commit || cmd.del_commit || cmd.tick_flush ||
                    (cmd.tick_take && pend_valid_r);

  always_comb begin
    st_nxt    = ST_FAIL;
    id_nxt    = '0;
    due_nxt   = '0;
    begin_nxt = '0;
    type_nxt  = '0;
    prio_nxt  = '0;
    last_nxt  = 1'b1;
    if (cmd.ins_commit) begin
      st_nxt = best_found_r ? ST_INSERTED : ST_FAIL;
      id_nxt = best_found_r ? new_id : '0;
    end else if (cmd.del_commit) begin
      st_nxt = best_found_r ? ST_DELETED : ST_FAIL;
      id_nxt = req_tid_r;
    end else begin
      st_nxt    = ST_EXPIRED;
      id_nxt    = pend_r.id;
      due_nxt   = pend_r.due;
      begin_nxt = pend_r.start;
      type_nxt  = pend_r.etype;
      prio_nxt  = pend_r.prio;
      last_nxt  = cmd.tick_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= st_nxt;
      out_id_r     <= id_nxt;
      out_due_r    <= due_nxt;
      out_begin_r  <= begin_nxt;
      out_type_r   <= type_nxt;
      out_prio_r   <= prio_nxt;
      out_last_r   <= last_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      id_counter_r <= '0;
      cand_vld_r   <= 1'b0;
      best_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
      res_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      count_r    <= count_nxt;
      cand_vld_r <= cmd.scan_rd;
      if (cfg_wr_en) id_counter_r <= cfg_wr_data;
      else if (ins_do) id_counter_r <= new_id;
      if (cmd.scan_start) best_found_r <= 1'b0;
      else if (take) best_found_r <= 1'b1;
      if (cmd.capture || cmd.tick_flush) pend_valid_r <= 1'b0;
      else if (cmd.tick_take) pend_valid_r <= 1'b1;
      if (cmd.capture) res_cnt_r <= '0;
      else if (cmd.tick_take) res_cnt_r <= res_cnt_r + RES_W'(1);
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_comb begin
    sts.kind       = req_kind_r;
    sts.best_found = best_found_r;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
    sts.res_full   = (res_cnt_r == RES_W'(MAX_RESULTS - 1));
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_id    = out_id_r;
  assign out_due_stamp   = out_due_r;
  assign out_begin_stamp = out_begin_r;
  assign out_type        = out_type_r;
  assign out_priority    = out_prio_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ----- src/deadline_reminder_queue.sv -----
// top level of the deadline reminder queue: controller, datapath and checks
// A table of DEPTH (16) timed entries served one request at a time. An insert
// takes the lowest free slot and answers with the next id (wrapping past 999 to
// 0) or a full status; a delete removes the oldest entry with the given id; a
// tick emits, in stamp order with ties going to the oldest entry, every entry
// whose reminder stamp lies strictly before the tick time, removes it and
// marks the final result with last. Each request is served by scans of the
// slot memory, one slot per cycle through its single read port; a tick rescans
// the table to find each next expired entry, and a stall on the result side
// holds each commit. Writing first_id loads the id counter; the user must do
// this only while no request is in flight, as the block does not enforce it.
`default_nettype none

module deadline_reminder_queue import drq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [STAMP_W-1:0] in_remind_stamp,
  input  wire logic [STAMP_W-1:0] in_start_stamp,
  input  wire logic [CODE_W-1:0]  in_entry_type,
  input  wire logic [CODE_W-1:0]  in_priority_req,
  input  wire logic [ID_W-1:0]    in_target_id,
  input  wire logic [STAMP_W-1:0] in_now_stamp,
  // first_id register
  input  wire logic               cfg_wr_en,
  input  wire logic [ID_W-1:0]    cfg_wr_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [ID_W-1:0]         out_entry_id,
  output logic [STAMP_W-1:0]      out_due_stamp,
  output logic [STAMP_W-1:0]      out_begin_stamp,
  output logic [CODE_W-1:0]       out_type,
  output logic [CODE_W-1:0]       out_priority,
  output logic                    out_last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: runs the slot scans and decides when to commit
  drq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memory, rank cells, search registers and the result register
  drq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_remind_stamp (in_remind_stamp),
    .in_start_stamp  (in_start_stamp),
    .in_entry_type   (in_entry_type),
    .in_priority_req (in_priority_req),
    .in_target_id    (in_target_id),
    .in_now_stamp    (in_now_stamp),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_id    (out_entry_id),
    .out_due_stamp   (out_due_stamp),
    .out_begin_stamp (out_begin_stamp),
    .out_type        (out_type),
    .out_priority    (out_priority),
    .out_last        (out_last)
  );

`ifndef SYNTH
  // a request with a real kind keeps the block busy afterwards
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && ((in_kind == KIND_INSERT) || (in_kind == KIND_DELETE) ||
     (in_kind == KIND_TICK))) |=> in_stall)
    else $error("block not busy after accepting a request");

  // capture and the commit commands never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.ins_commit, cmd.del_commit, cmd.tick_take,
              cmd.tick_flush}))
    else $error("overlapping datapath commands");

  // memory scans only happen while a request is in flight
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> in_stall)
    else $error("slot scan while idle");
`endif

endmodule

`default_nettype wire

// ----- tb/deadline_reminder_queue_tb.sv -----
`timescale 1ns / 100ps
// testbench for the deadline reminder queue: random and directed requests checked against a table model

module deadline_reminder_queue_tb;
  import drq_pkg::*;

  localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
  localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;  // ignored by the block
  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 60;    // covers a tick that expires nothing

  // one request as it sits on the input ports
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] remind;
    logic [STAMP_W-1:0] start;
    logic [CODE_W-1:0]  etype;
    logic [CODE_W-1:0]  prio;
    logic [ID_W-1:0]    target;
    logic [STAMP_W-1:0] now;
  } request_t;

  // one reply as it leaves on the output ports
  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] due;
    logic [STAMP_W-1:0] start;
    logic [CODE_W-1:0]  etype;
    logic [CODE_W-1:0]  prio;
    logic               last;
  } reply_t;

  // ports
  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  in_kind         = '0;
  logic [STAMP_W-1:0] in_remind_stamp = '0;
  logic [STAMP_W-1:0] in_start_stamp  = '0;
  logic [CODE_W-1:0]  in_entry_type   = '0;
  logic [CODE_W-1:0]  in_priority_req = '0;
  logic [ID_W-1:0]    in_target_id    = '0;
  logic [STAMP_W-1:0] in_now_stamp    = '0;
  logic               cfg_wr_en       = 1'b0;
  logic [ID_W-1:0]    cfg_wr_data     = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [1:0]         out_status;
  logic [ID_W-1:0]    out_entry_id;
  logic [STAMP_W-1:0] out_due_stamp;
  logic [STAMP_W-1:0] out_begin_stamp;
  logic [CODE_W-1:0]  out_type;
  logic [CODE_W-1:0]  out_priority;
  logic               out_last;

  // shadow of the reminder table
  bit                 slot_live  [DEPTH];
  logic [ID_W-1:0]    slot_id    [DEPTH];
  logic [STAMP_W-1:0] slot_due   [DEPTH];
  logic [STAMP_W-1:0] slot_start [DEPTH];
  logic [CODE_W-1:0]  slot_type  [DEPTH];
  logic [CODE_W-1:0]  slot_prio  [DEPTH];
  int unsigned        slot_rank  [DEPTH];  // insertion order, lower is older
  logic [ID_W-1:0]    last_id    = '0;     // id counter, reset value of first_id
  int unsigned        rank_count = 0;

  request_t request_queue [$];  // requests waiting for the driver
  reply_t   reply_queue   [$];  // replies the block still owes

  // driver and monitor state
  request_t           on_wire = '0;
  request_t           next_req;
  bit                 next_valid;
  bit                 req_live = 1'b0;  // blocking copy of in_valid for the sequencer
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 error_count   = 0;
  int                 quiet_cycles  = 0;
  reply_t             got;
  reply_t             want;
  logic [STAMP_W-1:0] window;  // time region where most stamps fall

  deadline_reminder_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_remind_stamp (in_remind_stamp),
    .in_start_stamp  (in_start_stamp),
    .in_entry_type   (in_entry_type),
    .in_priority_req (in_priority_req),
    .in_target_id    (in_target_id),
    .in_now_stamp    (in_now_stamp),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_id    (out_entry_id),
    .out_due_stamp   (out_due_stamp),
    .out_begin_stamp (out_begin_stamp),
    .out_type        (out_type),
    .out_priority    (out_priority),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic reply_t make_reply(input status_t st, input logic [ID_W-1:0] id,
                                        input logic [STAMP_W-1:0] due, start,
                                        input logic [CODE_W-1:0] etype, prio,
                                        input logic last);
    reply_t r;
    r.status = st;
    r.id     = id;
    r.due    = due;
    r.start  = start;
    r.etype  = etype;
    r.prio   = prio;
    r.last   = last;
    return r;
  endfunction

  // table update and expected replies for one accepted request
  task automatic apply_request(input request_t r);
    int     pick;
    reply_t held;
    bit     have_held;
    pick      = -1;
    held      = '0;
    have_held = 1'b0;
    case (r.kind)
      KIND_INSERT: begin
        // lowest free slot
        for (int i = DEPTH - 1; i >= 0; i--)
          if (!slot_live[i]) pick = i;
        if (pick < 0) begin
          // full table keeps the counter
          reply_queue.push_back(make_reply(ST_FAIL, '0, '0, '0, '0, '0, 1'b1));
        end else begin
          last_id           = (last_id >= ID_TOP) ? '0 : last_id + 1'b1;
          slot_live[pick]   = 1'b1;
          slot_id[pick]     = last_id;
          slot_due[pick]    = r.remind;
          slot_start[pick]  = r.start;
          slot_type[pick]   = r.etype;
          slot_prio[pick]   = r.prio;
          slot_rank[pick]   = rank_count;
          rank_count++;
          reply_queue.push_back(make_reply(ST_INSERTED, last_id, '0, '0, '0, '0, 1'b1));
        end
      end
      KIND_DELETE: begin
        // oldest entry holding the id
        for (int i = 0; i < DEPTH; i++)
          if (slot_live[i] && slot_id[i] == r.target &&
              (pick < 0 || slot_rank[i] < slot_rank[pick]))
            pick = i;
        if (pick < 0) begin
          reply_queue.push_back(make_reply(ST_FAIL, r.target, '0, '0, '0, '0, 1'b1));
        end else begin
          slot_live[pick] = 1'b0;
          reply_queue.push_back(make_reply(ST_DELETED, r.target, '0, '0, '0, '0, 1'b1));
        end
      end
      KIND_TICK: begin
        // earliest stamp strictly before now, oldest on a tie; one reply held back for last
        for (int n = 0; n < MAX_RESULTS; n++) begin
          pick = -1;
          for (int i = 0; i < DEPTH; i++)
            if (slot_live[i] && slot_due[i] < r.now &&
                (pick < 0 || slot_due[i] < slot_due[pick] ||
                 (slot_due[i] == slot_due[pick] && slot_rank[i] < slot_rank[pick])))
              pick = i;
          if (pick < 0) break;
          if (have_held) reply_queue.push_back(held);
          held = make_reply(ST_EXPIRED, slot_id[pick], slot_due[pick], slot_start[pick],
                            slot_type[pick], slot_prio[pick], 1'b0);
          have_held       = 1'b1;
          slot_live[pick] = 1'b0;
        end
        if (have_held) begin
          held.last = 1'b1;
          reply_queue.push_back(held);
        end
      end
      default: ;  // unused code, no reply
    endcase
  endtask

  // request driver: presents the next queued request, holds it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_req   = on_wire;
      if (in_valid && !in_stall) begin
        apply_request(on_wire);
        next_valid = 1'b0;
      end
      // random sender gaps, never decided by stall
      if (!next_valid && request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req   = request_queue.pop_front();
        next_valid = 1'b1;
      end
      req_live        = next_valid;
      in_valid        <= next_valid;
      on_wire         <= next_req;
      in_kind         <= next_req.kind;
      in_remind_stamp <= next_req.remind;
      in_start_stamp  <= next_req.start;
      in_entry_type   <= next_req.etype;
      in_priority_req <= next_req.prio;
      in_target_id    <= next_req.target;
      in_now_stamp    <= next_req.now;
    end
  end

  // reply monitor: random stall, each accepted reply against the oldest expected one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = make_reply(status_t'(out_status), out_entry_id, out_due_stamp, out_begin_stamp,
                         out_type, out_priority, out_last);
        if (reply_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected reply status %0d id %0d", got.status, got.id));
        end else begin
          want = reply_queue.pop_front();
          if (got.status !== want.status || got.id !== want.id || got.due !== want.due ||
              got.start !== want.start || got.etype !== want.etype ||
              got.prio !== want.prio || got.last !== want.last)
            flag_mismatch($sformatf(
              "got st %0d id %0d due %h beg %h ty %0d pr %0d last %0b, want %0d %0d %h %h %0d %0d %0b",
              got.status, got.id, got.due, got.start, got.etype, got.prio, got.last,
              want.status, want.id, want.due, want.start, want.etype, want.prio, want.last));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[STAMP_W-1:0];
  endfunction

  // request of the given kind with every other field random
  function automatic request_t noise_request(input logic [KIND_W-1:0] kind);
    request_t r;
    r.kind   = kind;
    r.remind = rand_stamp();
    r.start  = rand_stamp();
    r.etype  = CODE_W'($urandom_range(3));
    r.prio   = CODE_W'($urandom_range(3));
    r.target = ID_W'($urandom_range(1023));
    r.now    = rand_stamp();
    return r;
  endfunction

  function automatic int random_live_slot();
    int hits [$];
    for (int i = 0; i < DEPTH; i++)
      if (slot_live[i]) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  // keep the driver fed but only a couple of requests ahead
  task automatic send(input request_t r);
    while (request_queue.size() >= 2) @(posedge clk);
    request_queue.push_back(r);
  endtask

  task automatic send_insert(input logic [STAMP_W-1:0] remind, start,
                             input logic [CODE_W-1:0] etype, prio);
    request_t r;
    r        = noise_request(KIND_INSERT);
    r.remind = remind;
    r.start  = start;
    r.etype  = etype;
    r.prio   = prio;
    send(r);
  endtask

  task automatic send_delete(input logic [ID_W-1:0] id);
    request_t r;
    r        = noise_request(KIND_DELETE);
    r.target = id;
    send(r);
  endtask

  task automatic send_tick(input logic [STAMP_W-1:0] now);
    request_t r;
    r     = noise_request(KIND_TICK);
    r.now = now;
    send(r);
  endtask

  // nothing queued, nothing on the wire, nothing owed, then let a silent tick finish
  task automatic wait_drained();
    while (request_queue.size() != 0 || req_live || reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_id(input logic [ID_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    last_id = value;  // the write also loads the id counter
  endtask

  // mixed traffic: most stamps near a moving window so ticks expire some entries
  task automatic run_random(input int count);
    int                 made;
    int                 roll;
    int                 s;
    logic [STAMP_W-1:0] stamp;
    made   = 0;
    window = rand_stamp();
    while (made < count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send(noise_request(KIND_UNUSED));  // ignored request, not counted
      end else if (roll < 50) begin
        made++;
        stamp = ($urandom_range(99) < 85) ? window + $urandom_range(63) : rand_stamp();
        send_insert(stamp, rand_stamp(), CODE_W'($urandom_range(3)),
                    CODE_W'($urandom_range(3)));
      end else if (roll < 72) begin
        made++;
        s = random_live_slot();
        if (s >= 0 && $urandom_range(99) < 80) send_delete(slot_id[s]);
        else send_delete(ID_W'($urandom_range(1023)));
      end else begin
        made++;
        s    = random_live_slot();
        roll = $urandom_range(99);
        if (roll < 45) stamp = window + $urandom_range(70);
        else if (roll < 70 && s >= 0) stamp = slot_due[s] + $urandom_range(1);  // equal or just past
        else if (roll < 80) stamp = rand_stamp();
        else if (roll < 88) stamp = STAMP_MAX;
        else stamp = STAMP_W'($urandom_range(255));
        send_tick(stamp);
        if ($urandom_range(99) < 35) window = window + $urandom_range(64);
        else if ($urandom_range(99) < 3) window = rand_stamp();
      end
    end
  endtask

  // sequencer
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 55;

    // counter at the top, first id wraps to zero
    write_first_id(ID_TOP);
    send_tick('0);                                 // empty table, no reply
    send('1);                                      // unused code with every field high
    send_delete('1);                               // miss on an empty table
    send_insert(STAMP_MAX, '0, 2'd3, 2'd0);        // id 0
    send_insert('0, STAMP_MAX, 2'd0, 2'd3);        // id 1
    send_insert(40'd100, 40'd5, 2'd1, 2'd2);       // id 2
    send_insert(40'd100, 40'd6, 2'd2, 2'd1);       // id 3, same stamp as id 2
    send_tick(40'd100);                            // stamps equal to now stay
    send_tick(40'd101);                            // tie goes to the older entry
    send_delete(ID_W'(0));                         // hit
    send_delete(ID_W'(0));                         // already gone
    send_insert(40'd200, 40'd7, 2'd1, 2'd1);       // id 4
    wait_drained();

    // rewind the counter so id 4 is handed out twice
    write_first_id(ID_W'(3));
    send_insert(40'd300, 40'd8, 2'd2, 2'd3);       // second id 4
    send_delete(ID_W'(4));                         // removes the older id 4
    repeat (DEPTH - 1) send_insert(rand_stamp() >> 1, rand_stamp(), CODE_W'($urandom_range(3)),
                                   CODE_W'($urandom_range(3)));
    send_insert(rand_stamp(), rand_stamp(), 2'd3, 2'd3);  // table full
    send_tick(STAMP_MAX);                          // whole table expires in one tick
    wait_drained();

    // counter above the top also wraps
    write_first_id(ID_W'(1023));
    run_random(150);
    wait_drained();

    send_idle_pct = 55;
    recv_idle_pct = 37;
    write_first_id('0);
    run_random(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_first_id(ID_W'($urandom_range(1, 998)));
    run_random(150);
    wait_drained();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
